/* hw/rtl/qec_pkg.sv */
package qec_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN = 24;
    localparam int NSTG = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [35:0] GAIN_Q30 = 36'sd652032874;
    localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;

    typedef struct packed {
        logic mode;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] roll_in;
        logic signed [15:0] pitch_in;
        logic signed [15:0] yaw_in;
    } qec_in_t;

    typedef struct packed {
        logic signed [15:0] roll_out;
        logic signed [15:0] pitch_out;
        logic signed [15:0] yaw_out;
        logic signed [15:0] w_out;
        logic signed [15:0] x_out;
        logic signed [15:0] y_out;
        logic signed [15:0] z_out;
        logic pitch_clamped;
    } qec_out_t;

    function automatic logic signed [35:0] atan_tab(input int i);
        logic signed [35:0] t;
        begin
            unique case (i)
                0: t = 36'sd843314856;
                1: t = 36'sd497837829;
                2: t = 36'sd263043836;
                3: t = 36'sd133525158;
                4: t = 36'sd67021686;
                5: t = 36'sd33543515;
                6: t = 36'sd16775850;
                7: t = 36'sd8388437;
                8: t = 36'sd4194282;
                9: t = 36'sd2097149;
                10: t = 36'sd1048575;
                11: t = 36'sd524287;
                12: t = 36'sd262143;
                13: t = 36'sd131071;
                14: t = 36'sd65535;
                15: t = 36'sd32767;
                16: t = 36'sd16383;
                17: t = 36'sd8191;
                18: t = 36'sd4095;
                19: t = 36'sd2047;
                20: t = 36'sd1023;
                21: t = 36'sd511;
                22: t = 36'sd255;
                23: t = 36'sd127;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

    function automatic logic signed [15:0] rsat(input logic signed [79:0] v, input int s);
        logic signed [79:0] r;
        begin
            r = (v + (80'sd1 <<< (s - 1))) >>> s;
            if (r > 80'sd32767)
                return 16'sh7fff;
            else if (r < -80'sd32768)
                return 16'sh8000;
            else
                return r[15:0];
        end
    endfunction

endpackage

/* hw/rtl/quaternion_euler_converter.sv */
// throughput: one transaction per cycle; busy is tied low
// the 29 square root steps run one result bit per pipeline stage alongside the first cordic
// results appear with done for exactly one cycle; the receiver cannot stall
// reset clears all valid bits asynchronously; payload registers are not reset
module quaternion_euler_converter
    import qec_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  qec_in_t in_data,
    output logic done,
    output qec_out_t out_data
);

    localparam int NS = NSTG;
    localparam int SQ = 29;
    localparam int CS = (NS > SQ) ? NS : SQ;
    localparam int DEPTH = 3 + CS + NS + 4;

    typedef struct packed {
        logic mode;
        logic clamp;
        logic csign;
        logic signed [47:0] ax, ay, bx, by, cx, cy;
        logic signed [35:0] az, bz, cz;
        logic [1:0] neg;
        logic neg_c;
        logic [57:0] rem;
        logic [57:0] res;
        logic [57:0] bit_m;
    } st_t;

    logic [DEPTH-1:0] vld_reg;
    logic signed [34:0] sr_reg, cr_reg, sp_reg, sy_reg, cy_reg;
    logic mode1_reg, mode2_reg;
    logic signed [15:0] ri_reg, pi_reg, yi_reg;
    logic signed [57:0] spsq_reg;
    logic signed [28:0] sp_lo;
    st_t st_reg [0:CS+NS];
    logic signed [35:0] ang_a_reg, ang_b_reg, ang_c_reg;
    logic signed [35:0] sa_reg, ca_reg, sb_reg, cb_reg, sc_reg, cc_reg;
    logic signed [31:0] p1_reg [0:7];
    logic signed [31:0] c3_reg [0:7];
    logic signed [63:0] t_reg [0:7];
    logic mode_f_reg [0:2];
    logic clamp_f_reg [0:2];
    logic signed [15:0] ro_reg, po_reg, yo_reg, wo_reg, xo_reg, yqo_reg, zo_reg;
    logic pcl_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[DEPTH-2:0], start};
    end

    assign done = vld_reg[DEPTH-1];

    // stage 0: products and sums
    always_ff @(posedge clk)
    begin
        sr_reg <= 35'(2 * (35'(in_data.quat_w * in_data.quat_x)
            + 35'(in_data.quat_y * in_data.quat_z)));
        cr_reg <= ONE_Q28 - 35'(2 * (35'(in_data.quat_x * in_data.quat_x)
            + 35'(in_data.quat_y * in_data.quat_y)));
        sp_reg <= 35'(2 * (35'(in_data.quat_w * in_data.quat_y)
            - 35'(in_data.quat_z * in_data.quat_x)));
        sy_reg <= 35'(2 * (35'(in_data.quat_w * in_data.quat_z)
            + 35'(in_data.quat_x * in_data.quat_y)));
        cy_reg <= ONE_Q28 - 35'(2 * (35'(in_data.quat_y * in_data.quat_y)
            + 35'(in_data.quat_z * in_data.quat_z)));
        mode1_reg <= in_data.mode;
        ri_reg <= in_data.roll_in;
        pi_reg <= in_data.pitch_in;
        yi_reg <= in_data.yaw_in;
    end

    // stage 1: pitch sine squared, only needed below one
    assign sp_lo = sp_reg[28:0];

    logic signed [34:0] sr1_reg, cr1_reg, sp1_reg, sy1_reg, cy1_reg;
    logic signed [15:0] ri1_reg, pi1_reg, yi1_reg;
    always_ff @(posedge clk)
    begin
        spsq_reg <= sp_lo * sp_lo;
        sr1_reg <= sr_reg;
        cr1_reg <= cr_reg;
        sp1_reg <= sp_reg;
        sy1_reg <= sy_reg;
        cy1_reg <= cy_reg;
        mode2_reg <= mode1_reg;
        ri1_reg <= ri_reg;
        pi1_reg <= pi_reg;
        yi1_reg <= yi_reg;
    end

    function automatic void pre_vec(input logic signed [47:0] y, input logic signed [47:0] x,
        output logic signed [47:0] yo, output logic signed [47:0] xo,
        output logic signed [35:0] zo);
        begin
            yo = y;
            xo = x;
            zo = '0;
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    xo = y;
                    yo = -x;
                    zo = HALF_PI_Q30;
                end
                else
                begin
                    xo = -y;
                    yo = x;
                    zo = -HALF_PI_Q30;
                end
            end
        end
    endfunction

    function automatic void pre_rot(input logic signed [15:0] a,
        output logic signed [35:0] ao, output logic ng);
        logic signed [35:0] t;
        begin
            t = {{4{a[15]}}, a, 16'd0};
            ng = 1'b0;
            ao = t;
            if (t > HALF_PI_Q30)
            begin
                ao = t - PI_Q30;
                ng = 1'b1;
            end
            else if (t < -HALF_PI_Q30)
            begin
                ao = t + PI_Q30;
                ng = 1'b1;
            end
        end
    endfunction

    // stage 2: set up cordic entry
    st_t s0;
    always_comb
    begin
        logic signed [47:0] yy, xx;
        logic signed [35:0] zz;
        logic signed [35:0] an;
        logic ng;
        yy = '0;
        xx = '0;
        zz = '0;
        an = '0;
        ng = 1'b0;
        s0 = '0;
        s0.mode = mode2_reg;
        s0.clamp = (sp1_reg >= ONE_Q28) || (sp1_reg <= -ONE_Q28);
        s0.csign = sp1_reg > 0;
        if (!mode2_reg)
        begin
            pre_vec(48'(sr1_reg), 48'(cr1_reg), yy, xx, zz);
            s0.ay = yy; s0.ax = xx; s0.az = zz;
            pre_vec(48'(sy1_reg), 48'(cy1_reg), yy, xx, zz);
            s0.cy = yy; s0.cx = xx; s0.cz = zz;
            s0.by = 48'(sp1_reg);
            s0.rem = 58'((59'd1 << 56) - 59'(spsq_reg));
            s0.bit_m = 58'd1 << 56;
        end
        else
        begin
            pre_rot(ri1_reg, an, ng);
            s0.ax = 48'(GAIN_Q30); s0.az = an; s0.neg[0] = ng;
            pre_rot(pi1_reg, an, ng);
            s0.bx = 48'(GAIN_Q30); s0.bz = an; s0.neg[1] = ng;
            pre_rot(yi1_reg, an, ng);
            s0.cx = 48'(GAIN_Q30); s0.cz = an; s0.neg_c = ng;
        end
    end

    always_ff @(posedge clk)
        st_reg[0] <= s0;

    function automatic void vec_step(input int i, inout logic signed [47:0] x,
        inout logic signed [47:0] y, inout logic signed [35:0] z);
        logic signed [47:0] dx, dy;
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0)
            begin
                x = x - dx; y = y + dy; z = z - atan_tab(i);
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + atan_tab(i);
            end
        end
    endfunction

    function automatic void rot_step(input int i, inout logic signed [47:0] x,
        inout logic signed [47:0] y, inout logic signed [35:0] a);
        logic signed [47:0] dx, dy;
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0)
            begin
                x = x - dx; y = y + dy; a = a - atan_tab(i);
            end
            else
            begin
                x = x + dx; y = y - dy; a = a + atan_tab(i);
            end
        end
    endfunction

    // first chain: roll/yaw vectoring or all rotations, plus square root
    // second chain: pitch vectoring against the root
    for (genvar g = 0; g < CS + NS; g++)
    begin : g_stg
        st_t s;
        always_comb
        begin
            logic signed [47:0] x, y;
            logic signed [35:0] z;
            logic [57:0] t;
            x = '0;
            y = '0;
            z = '0;
            t = '0;
            s = st_reg[g];
            if (g < CS)
            begin
                if (g < NS)
                begin
                    x = s.ax; y = s.ay; z = s.az;
                    if (s.mode) rot_step(g, x, y, z); else vec_step(g, x, y, z);
                    s.ax = x; s.ay = y; s.az = z;
                    x = s.cx; y = s.cy; z = s.cz;
                    if (s.mode) rot_step(g, x, y, z); else vec_step(g, x, y, z);
                    s.cx = x; s.cy = y; s.cz = z;
                    if (s.mode)
                    begin
                        x = s.bx; y = s.by; z = s.bz;
                        rot_step(g, x, y, z);
                        s.bx = x; s.by = y; s.bz = z;
                    end
                end
                if (!s.mode)
                begin
                    t = s.res + s.bit_m;
                    if (s.rem >= t)
                    begin
                        s.rem = s.rem - t;
                        s.res = (s.res >> 1) + s.bit_m;
                    end
                    else
                        s.res = s.res >> 1;
                    s.bit_m = s.bit_m >> 2;
                    if (g == CS - 1)
                    begin
                        s.bx = 48'(s.res);
                        s.bz = '0;
                        if (s.bx == 0 && s.by == 0)
                            s.bz = '0;
                        else
                        begin
                            pre_vec(s.by, s.bx, y, x, z);
                            s.by = y; s.bx = x; s.bz = z;
                        end
                    end
                end
            end
            else if (!s.mode && !(s.bx == 0 && s.by == 0 && s.bz == 0 && g == CS))
            begin
                x = s.bx; y = s.by; z = s.bz;
                vec_step(g - CS, x, y, z);
                s.bx = x; s.by = y; s.bz = z;
            end
        end
        always_ff @(posedge clk)
            st_reg[g+1] <= s;
    end

    // zero vectors give zero angle
    st_t se;
    assign se = st_reg[CS+NS];

    logic zero_a, zero_c;

    // zero flags tracked from entry
    logic [CS+NS:0] za_reg, zc_reg;
    always_ff @(posedge clk)
    begin
        za_reg <= {za_reg[CS+NS-1:0], (sr1_reg == 0 && cr1_reg == 0)};
        zc_reg <= {zc_reg[CS+NS-1:0], (sy1_reg == 0 && cy1_reg == 0)};
    end
    assign zero_a = za_reg[CS+NS];
    assign zero_c = zc_reg[CS+NS];

    // products: stage A first pair products, stage B triple, stage C sums
    logic signed [31:0] sa, ca, sb, cb, sc, cc;
    always_comb
    begin
        sa = se.neg[0] ? -32'(se.ay) : 32'(se.ay);
        ca = se.neg[0] ? -32'(se.ax) : 32'(se.ax);
        sb = se.neg[1] ? -32'(se.by) : 32'(se.by);
        cb = se.neg[1] ? -32'(se.bx) : 32'(se.bx);
        sc = se.neg_c ? -32'(se.cy) : 32'(se.cy);
        cc = se.neg_c ? -32'(se.cx) : 32'(se.cx);
    end

    always_ff @(posedge clk)
    begin
        p1_reg[0] <= 32'((64'(ca) * 64'(cb)) >>> 30);
        p1_reg[1] <= 32'((64'(sa) * 64'(sb)) >>> 30);
        p1_reg[2] <= 32'((64'(sa) * 64'(cb)) >>> 30);
        p1_reg[3] <= 32'((64'(ca) * 64'(sb)) >>> 30);
        p1_reg[4] <= 32'((64'(ca) * 64'(sb)) >>> 30);
        p1_reg[5] <= 32'((64'(sa) * 64'(cb)) >>> 30);
        p1_reg[6] <= 32'((64'(ca) * 64'(cb)) >>> 30);
        p1_reg[7] <= 32'((64'(sa) * 64'(sb)) >>> 30);
        c3_reg[0] <= cc; c3_reg[1] <= sc; c3_reg[2] <= cc; c3_reg[3] <= sc;
        c3_reg[4] <= cc; c3_reg[5] <= sc; c3_reg[6] <= sc; c3_reg[7] <= cc;
        ang_a_reg <= zero_a ? '0 : se.az;
        ang_c_reg <= zero_c ? '0 : se.cz;
        ang_b_reg <= se.clamp ? (se.csign ? HALF_PI_Q30 : -HALF_PI_Q30) : se.bz;
        mode_f_reg[0] <= se.mode;
        clamp_f_reg[0] <= se.clamp;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 8; k++)
            t_reg[k] <= 64'(p1_reg[k]) * 64'(c3_reg[k]);
        sa_reg <= ang_a_reg;
        sb_reg <= ang_b_reg;
        sc_reg <= ang_c_reg;
        mode_f_reg[1] <= mode_f_reg[0];
        clamp_f_reg[1] <= clamp_f_reg[0];
    end

    logic signed [63:0] sum_reg [0:3];
    always_ff @(posedge clk)
    begin
        sum_reg[0] <= t_reg[0] + t_reg[1];
        sum_reg[1] <= t_reg[2] - t_reg[3];
        sum_reg[2] <= t_reg[4] + t_reg[5];
        sum_reg[3] <= t_reg[6] - t_reg[7];
        ca_reg <= sa_reg;
        cb_reg <= sb_reg;
        cc_reg <= sc_reg;
        mode_f_reg[2] <= mode_f_reg[1];
        clamp_f_reg[2] <= clamp_f_reg[1];
    end

    always_ff @(posedge clk)
    begin
        if (mode_f_reg[2])
        begin
            ro_reg <= '0; po_reg <= '0; yo_reg <= '0; pcl_reg <= 1'b0;
            wo_reg <= rsat(80'(sum_reg[0]), 46);
            xo_reg <= rsat(80'(sum_reg[1]), 46);
            yqo_reg <= rsat(80'(sum_reg[2]), 46);
            zo_reg <= rsat(80'(sum_reg[3]), 46);
        end
        else
        begin
            ro_reg <= rsat(80'(ca_reg), 17);
            po_reg <= rsat(80'(cb_reg), 17);
            yo_reg <= rsat(80'(cc_reg), 17);
            pcl_reg <= clamp_f_reg[2];
            wo_reg <= '0; xo_reg <= '0; yqo_reg <= '0; zo_reg <= '0;
        end
    end

    always_comb
    begin
        out_data.roll_out = ro_reg;
        out_data.pitch_out = po_reg;
        out_data.yaw_out = yo_reg;
        out_data.w_out = wo_reg;
        out_data.x_out = xo_reg;
        out_data.y_out = yqo_reg;
        out_data.z_out = zo_reg;
        out_data.pitch_clamped = pcl_reg;
    end

endmodule
